[design/fuls_pkg.sv]
// -----------------------------------------------------------------------------
// fuls_pkg
// Shared types and constants for the first-unique-letter stream core.
// -----------------------------------------------------------------------------
package fuls_pkg;

  localparam int AlphabetSize = 26;
  localparam int LetterW      = 5;
  localparam int PtrW         = $clog2(AlphabetSize);
  localparam int FillW        = $clog2(AlphabetSize + 1);
  localparam int CountW       = 2;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PtrW-1:0]    ptr_t;
  typedef logic [FillW-1:0]   fill_t;
  typedef logic [CountW-1:0]  count_t;

  localparam count_t CountNone = 2'd0;
  localparam count_t CountOnce = 2'd1;
  localparam count_t CountMany = 2'd2;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StUpd  = 5'b00010,
    StPopA = 5'b00100,
    StPopB = 5'b01000,
    StPopC = 5'b10000
  } state_e;

  // advance a ring pointer, wrap at the alphabet size
  function automatic ptr_t next_slot(ptr_t p);
    ptr_t res;
    if ({1'b0, p} + (PtrW+1)'(1) >= (PtrW+1)'(AlphabetSize)) begin
      res = '0;
    end else begin
      res = p + ptr_t'(1);
    end
    return res;
  endfunction

endpackage

[design/first_unique_letter_stream_core.sv]
// Flow: an accepted item passes StUpd, then StPopA; with the queue empty the
//   result is reported from StPopA, else StPopB and StPopC check the front, which
//   is reported or popped before StPopA again. A new item is taken only in StIdle;
//   each queue check costs a fifo memory read followed by a count memory read.
// Reset: rst_ni clears the counts (per-letter valid bits), the queue pointers
//   and the control state; the order memory is not cleared.
// -----------------------------------------------------------------------------
// first_unique_letter_stream_core
// Streams letters and reports the earliest letter seen exactly once so far in
// the current string, using a count memory and an order queue memory.
// -----------------------------------------------------------------------------
module first_unique_letter_stream_core
  import fuls_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [4:0]      letter_i,
  input  logic            string_start_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            has_answer_o,
  output logic [4:0]      answer_letter_o
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e  state_q, state_d;
  letter_t letter_q;
  ptr_t    head_q, head_d;
  ptr_t    tail_q, tail_d;
  fill_t   fill_q, fill_d;

  // One valid bit per letter: a letter whose bit is low counts as never seen.
  // A new string drops all of them at once, so the count memory needs no sweep.
  logic [AlphabetSize-1:0] cnt_vld_q, cnt_vld_d;

  // Output register: holds a finished result while the next item is taken.
  logic    out_valid_q, out_valid_d;
  logic    has_answer_q, has_answer_d;
  letter_t answer_q, answer_d;

  // ---------------------------------------------------------------------------
  // Memories (registered read)
  // ---------------------------------------------------------------------------
  count_t  cnt_mem [AlphabetSize];
  letter_t fifo_mem [AlphabetSize];

  logic    cnt_re, cnt_we;
  letter_t cnt_raddr;
  count_t  cnt_wdata;
  count_t  cnt_rdata_q;

  logic    fifo_re, fifo_we;
  letter_t fifo_rdata_q;

  logic    accept;
  logic    out_free;
  logic    letter_in_range;
  logic    front_in_range;
  count_t  letter_cnt;
  count_t  front_cnt;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;

  assign letter_in_range = ({1'b0, letter_q} < (LetterW+1)'(AlphabetSize));
  assign front_in_range  = ({1'b0, fifo_rdata_q} < (LetterW+1)'(AlphabetSize));

  // Mask stale memory contents with the per-letter valid bit.
  assign letter_cnt = (letter_in_range && cnt_vld_q[letter_q]) ? cnt_rdata_q : CountNone;
  assign front_cnt  = (front_in_range && cnt_vld_q[fifo_rdata_q]) ? cnt_rdata_q : CountNone;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    cnt_vld_d    = cnt_vld_q;
    out_valid_d  = out_valid_q;
    has_answer_d = has_answer_q;
    answer_d     = answer_q;
    cnt_re       = 1'b0;
    cnt_raddr    = letter_i;
    cnt_we       = 1'b0;
    cnt_wdata    = CountOnce;
    fifo_re      = 1'b0;
    fifo_we      = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          // fetch the count of the incoming letter; a new string clears first
          cnt_re    = 1'b1;
          cnt_raddr = letter_i;
          if (string_start_i) begin
            cnt_vld_d = '0;
            head_d    = '0;
            tail_d    = '0;
            fill_d    = '0;
          end
          state_d = StUpd;
        end
      end
      StUpd: begin
        // bump the count and queue the letter on its first sighting
        if (letter_in_range) begin
          cnt_we              = 1'b1;
          cnt_vld_d[letter_q] = 1'b1;
          if (letter_cnt == CountNone) begin
            cnt_wdata = CountOnce;
            if (fill_q < FillW'(AlphabetSize)) begin
              fifo_we = 1'b1;
              tail_d  = next_slot(tail_q);
              fill_d  = fill_q + FillW'(1);
            end
          end else begin
            cnt_wdata = CountMany;
          end
        end
        state_d = StPopA;
      end
      StPopA: begin
        if (fill_q == '0) begin
          // queue empty: report no answer once the output register is free
          if (out_free) begin
            out_valid_d  = 1'b1;
            has_answer_d = 1'b0;
            answer_d     = '0;
            state_d      = StIdle;
          end
        end else begin
          fifo_re = 1'b1;
          state_d = StPopB;
        end
      end
      StPopB: begin
        // look up the count of the queue front
        cnt_re    = 1'b1;
        cnt_raddr = fifo_rdata_q;
        state_d   = StPopC;
      end
      StPopC: begin
        if (front_in_range && (front_cnt == CountNone || front_cnt == CountOnce)) begin
          // front is still unique: report it, hold here while the sink stalls
          if (out_free) begin
            out_valid_d  = 1'b1;
            has_answer_d = 1'b1;
            answer_d     = fifo_rdata_q;
            state_d      = StIdle;
          end
        end else begin
          // front repeated: pop it and check the next one
          head_d  = next_slot(head_q);
          fill_d  = fill_q - FillW'(1);
          state_d = StPopA;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      cnt_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      cnt_vld_q   <= cnt_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      letter_q <= letter_i;
    end
    has_answer_q <= has_answer_d;
    answer_q     <= answer_d;
  end

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[letter_q] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  // Order queue memory: write at tail, registered read at head.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[tail_q] <= letter_q;
    end
    if (fifo_re) begin
      fifo_rdata_q <= fifo_mem[head_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign has_answer_o    = has_answer_q;
  assign answer_letter_o = answer_q;

`ifndef SYNTHESIS
  logic [PtrW:0] tail_exp_sum;
  ptr_t          tail_exp;
  assign tail_exp_sum = {1'b0, head_q} + (PtrW+1)'(fill_q);
  assign tail_exp = (tail_exp_sum >= (PtrW+1)'(AlphabetSize)) ?
                    PtrW'(tail_exp_sum - (PtrW+1)'(AlphabetSize)) : PtrW'(tail_exp_sum);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(AlphabetSize))
    else $error("queue fill exceeds alphabet size");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_exp)
    else $error("queue tail does not match head plus fill");

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StUpd)
    else $error("accepted transaction did not start an update");

  a_answer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_answer_o) |-> ({1'b0, answer_letter_o} < (LetterW+1)'(AlphabetSize)))
    else $error("reported letter out of range");

  a_no_answer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_answer_o) |-> answer_letter_o == '0)
    else $error("empty answer carries a letter");
`endif

endmodule

[sim/first_unique_letter_stream_core_tb.sv]
// -----------------------------------------------------------------------------
// first_unique_letter_stream_core_tb
// Streams letters into the core and checks every reported answer against a
// behavioral predictor that tracks letter counts and the order of first
// sightings. A short directed run covers the alphabet ends, ignored letters,
// count saturation and string restarts. A random run follows: mostly
// well-formed strings over alphabets of random span, full alphabet sweeps that
// fill the order queue, and noise with stray restarts and ignored letters.
// Both channels idle in random bursts, which stop near the end of the run.
// -----------------------------------------------------------------------------
module first_unique_letter_stream_core_tb;
  import fuls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemsTarget   = 1800;  // in-range letters to stream
  localparam int TailItems     = 150;   // no idling once this few are left
  localparam int DrainCycles   = 100;   // cycles to wait after the last answer
  localparam int WatchdogLimit = 2000;  // cycles with no transaction at all

  typedef struct packed {
    letter_t letter;
    logic    start;
  } letter_item_t;

  typedef struct packed {
    logic    has;
    letter_t letter;
  } answer_t;

  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    in_valid_i     = 1'b0;
  logic    in_ready_o;
  letter_t letter_i       = '0;
  logic    string_start_i = 1'b0;
  logic    out_valid_o;
  logic    out_ready_i    = 1'b0;
  logic    has_answer_o;
  letter_t answer_letter_o;

  // Predictor state: per-letter counts and the ring of first sightings.
  count_t  letter_tally [AlphabetSize];
  letter_t arrival_ring [AlphabetSize];
  int      ring_rd   = 0;
  int      ring_wr   = 0;
  int      ring_used = 0;

  letter_item_t letters_pending[$];
  answer_t      answers_due[$];
  letter_item_t next_item;
  answer_t      want;

  int items_total    = 0;
  int items_taken    = 0;
  int counted_items  = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int send_gap       = 0;
  int stall_left     = 0;
  int send_idle_pct  = 15;
  int recv_stall_pct = 4;
  int quiet_cycles   = 0;
  bit tail_phase     = 1'b0;

  first_unique_letter_stream_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .letter_i       (letter_i),
    .string_start_i (string_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .has_answer_o   (has_answer_o),
    .answer_letter_o(answer_letter_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one letter to the predicted store and return the answer it leaves.
  function automatic answer_t track_letter(letter_t l, logic fresh);
    answer_t res;
    letter_t front;
    logic    settled;
    if (fresh) begin
      foreach (letter_tally[i]) letter_tally[i] = CountNone;
      ring_rd   = 0;
      ring_wr   = 0;
      ring_used = 0;
    end
    if (l < AlphabetSize) begin
      if (letter_tally[l] == CountNone) begin
        letter_tally[l] = CountOnce;
        if (ring_used < AlphabetSize) begin
          arrival_ring[ring_wr] = l;
          ring_wr = (ring_wr + 1 >= AlphabetSize) ? 0 : ring_wr + 1;
          ring_used++;
        end
      end else begin
        letter_tally[l] = CountMany;
      end
    end
    // Drop repeated letters from the front until a single sighting shows up.
    settled = 1'b0;
    while (ring_used > 0 && !settled) begin
      front = arrival_ring[ring_rd];
      if (front < AlphabetSize && letter_tally[front] <= CountOnce) begin
        settled = 1'b1;
      end else begin
        ring_rd = (ring_rd + 1 >= AlphabetSize) ? 0 : ring_rd + 1;
        ring_used--;
      end
    end
    res.has    = (ring_used > 0);
    res.letter = res.has ? arrival_ring[ring_rd] : '0;
    return res;
  endfunction

  function automatic int idle_share();
    int pct;
    case ($urandom_range(3, 0))
      0:       pct = 0;
      1:       pct = 4;
      2:       pct = 15;
      default: pct = 40;
    endcase
    return pct;
  endfunction

  task automatic queue_letter(int l, bit start);
    letter_item_t it;
    it.letter = letter_t'(l);
    it.start  = start;
    letters_pending.insert(letters_pending.size(), it);
    items_total++;
    if (l < AlphabetSize) counted_items++;
  endtask

  // Driver: hold each transaction until accepted, then predict its answer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        answers_due.insert(answers_due.size(), track_letter(letter_i, string_start_i));
        items_taken++;
        if (items_taken % 200 == 0) send_idle_pct = idle_share();
        if (!tail_phase && $urandom_range(99, 0) < send_idle_pct) begin
          send_gap = $urandom_range(19, 1);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (letters_pending.size() > 0) begin
          next_item      = letters_pending.pop_front();
          letter_i       <= next_item.letter;
          string_start_i <= next_item.start;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      tail_phase = (letters_pending.size() < TailItems);
    end
  end

  // Monitor: check each result transaction and throttle out_ready_i.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $error("result with no answer pending: has_answer %0d answer_letter %0d",
                 has_answer_o, answer_letter_o);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (has_answer_o !== want.has) begin
            $error("has_answer mismatch: expected %0d, actual %0d", want.has, has_answer_o);
            mismatches++;
          end
          if (answer_letter_o !== want.letter) begin
            $error("answer_letter mismatch: expected %0d, actual %0d",
                   want.letter, answer_letter_o);
            mismatches++;
          end
          results_seen++;
          if (results_seen % 200 == 0) recv_stall_pct = idle_share();
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!tail_phase && $urandom_range(99, 0) < recv_stall_pct) begin
        stall_left = $urandom_range(18, 0);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int len;
    int span;
    int base;
    int perm[AlphabetSize];
    int j;
    int tmp;

    // Directed: alphabet ends, saturation, ignored letters, restarts.
    queue_letter(0, 1'b1);    // first letter of a string
    queue_letter(25, 1'b0);   // 'a' still leads
    queue_letter(0, 1'b0);    // 'a' repeats, 'z' takes over
    queue_letter(0, 1'b0);    // count stays saturated
    queue_letter(31, 1'b0);   // ignored, answer unchanged
    queue_letter(26, 1'b0);   // first ignored code
    queue_letter(25, 1'b0);   // nothing unique left
    queue_letter(16, 1'b0);
    queue_letter(31, 1'b1);   // restart on an ignored letter
    queue_letter(12, 1'b0);
    queue_letter(12, 1'b0);
    queue_letter(25, 1'b1);   // restart on a valid letter
    queue_letter(15, 1'b0);
    queue_letter(1, 1'b0);
    queue_letter(25, 1'b0);
    queue_letter(15, 1'b0);
    queue_letter(1, 1'b0);
    queue_letter(30, 1'b1);
    queue_letter(7, 1'b0);

    // Random: well-formed strings, full sweeps and noise.
    while (counted_items < ItemsTarget) begin
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
        // Sweep the whole alphabet to fill the order queue, then repeat some.
        foreach (perm[i]) perm[i] = i;
        for (int i = AlphabetSize - 1; i > 0; i--) begin
          j       = $urandom_range(i, 0);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        foreach (perm[i]) queue_letter(perm[i], i == 0);
        len = $urandom_range(30, 0);
        for (int i = 0; i < len; i++) queue_letter($urandom_range(AlphabetSize - 1, 0), 1'b0);
      end else if (kind <= 2) begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          queue_letter($urandom_range(31, 0), $urandom_range(7, 0) == 0);
        end
      end else begin
        len  = $urandom_range(30, 1);
        span = $urandom_range(AlphabetSize, 1);
        base = $urandom_range(AlphabetSize - span, 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19, 0) == 0) begin
            queue_letter($urandom_range(31, AlphabetSize), 1'b0);
          end else begin
            queue_letter(base + $urandom_range(span - 1, 0),
                         i == 0 || $urandom_range(39, 0) == 0);
          end
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != items_total) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
